FILE: hw/rtl/mnde_pkg.sv
package mnde_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_THRESHOLD       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_COMPARE_ENABLE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DOWN_COMPARE_ENABLE  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH          = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT         = 3'd4;

  localparam logic [7:0] EDGE_THRESHOLD_RESET       = 8'd16;
  localparam logic       RIGHT_COMPARE_ENABLE_RESET = 1'b1;
  localparam logic       DOWN_COMPARE_ENABLE_RESET  = 1'b1;
  localparam logic [8:0] IMAGE_WIDTH_RESET          = 9'd176;
  localparam logic [8:0] IMAGE_HEIGHT_RESET         = 9'd144;

  typedef struct packed {
    logic [7:0] grey_value;
    logic       mask_ok;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic       is_edge;
    logic [7:0] pixel_column;
    logic [7:0] pixel_row;
    logic       frame_done;
  } out_item_t;

  // one column of the line store: the two previous rows
  typedef struct packed {
    logic [7:0] grey_prev;
    logic       mask_prev;
    logic [7:0] grey_prev2;
    logic       mask_prev2;
  } line_entry_t;

  typedef struct packed {
    logic [7:0] edge_threshold;
    logic       right_compare_enable;
    logic       down_compare_enable;
  } cmp_cfg_t;

  typedef struct packed {
    logic       has_result;
    logic       interior;
    logic       frame_done;
    logic [7:0] column;
    logic [7:0] row;
  } pos_t;

endpackage

FILE: hw/rtl/mnde_ram.sv
module mnde_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/mnde_pos.sv
module mnde_pos import mnde_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic                         frame_start,
  input  logic [8:0]                   image_width,
  input  logic [8:0]                   image_height,
  output pos_t                         pos,
  output logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_addr
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int SWW = ($clog2(MAX_WIDTH + 1) > 9) ? $clog2(MAX_WIDTH + 1) : 9;
  localparam int SHW = ($clog2(MAX_HEIGHT + 1) > 9) ? $clog2(MAX_HEIGHT + 1) : 9;
  localparam int SWX = SWW + 1;

  logic [CW-1:0]  column_count, column_next;
  logic [RW-1:0]  row_count, row_next;

  logic [SWW-1:0] w_raw, w_eff, c0, c1, c_inc, rd_col;
  logic [SWX-1:0] c_plus3, w_ext;
  logic [SHW-1:0] h_raw, h_eff, r0, r1, r2, r_inc, y;

  always_comb begin
    w_raw = SWW'(image_width);
    h_raw = SHW'(image_height);
    if (w_raw < SWW'(4)) begin
      w_eff = SWW'(4);
    end else if (w_raw > SWW'(MAX_WIDTH)) begin
      w_eff = SWW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw < SHW'(4)) begin
      h_eff = SHW'(4);
    end else if (h_raw > SHW'(MAX_HEIGHT)) begin
      h_eff = SHW'(MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end

    c0 = frame_start ? '0 : SWW'(column_count);
    r0 = frame_start ? '0 : SHW'(row_count);

    // a stored position outside the current size wraps first
    if (c0 >= w_eff) begin
      c1 = '0;
      r1 = r0 + SHW'(1);
    end else begin
      c1 = c0;
      r1 = r0;
    end
    r2 = (r1 >= h_eff) ? '0 : r1;

    c_inc   = c1 + SWW'(1);
    r_inc   = r2 + SHW'(1);
    y       = r2 - SHW'(2);
    w_ext   = {1'b0, w_eff};
    c_plus3 = {1'b0, c1} + SWX'(3);

    // lookahead column three ahead, wrapping into the next line
    if (c_plus3 >= w_ext) begin
      rd_col = SWW'(c_plus3 - w_ext);
    end else begin
      rd_col = SWW'(c_plus3);
    end

    pos.has_result = (r2 >= SHW'(2));
    pos.interior   = (c_plus3 < w_ext) && (r_inc < h_eff);
    pos.frame_done = (c1 == w_eff - SWW'(1)) && (r2 == h_eff - SHW'(1));
    pos.column     = c1[7:0];
    pos.row        = y[7:0];

    wr_addr = c1[CW-1:0];
    rd_addr = rd_col[CW-1:0];

    if (c_inc >= w_eff) begin
      column_next = '0;
      row_next    = (r_inc >= h_eff) ? '0 : r_inc[RW-1:0];
    end else begin
      column_next = c_inc[CW-1:0];
      row_next    = r2[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (advance) begin
      column_count <= column_next;
      row_count    <= row_next;
    end
  end

endmodule

FILE: hw/rtl/mnde_edge.sv
module mnde_edge import mnde_pkg::*; (
  input  cmp_cfg_t    cfg,
  input  line_entry_t tap_x0,
  input  line_entry_t tap_x1,
  input  line_entry_t tap_x2,
  input  logic        mask_cur,
  input  logic        interior,
  output logic        is_edge
);

  logic [7:0] centre, right, below, diff_right, diff_down;
  logic       mask_all, right_hit, down_hit;

  always_comb begin
    centre = tap_x0.grey_prev2;
    right  = tap_x1.grey_prev2;
    below  = tap_x0.grey_prev;

    diff_right = (centre > right) ? (centre - right) : (right - centre);
    diff_down  = (centre > below) ? (centre - below) : (below - centre);

    mask_all = tap_x0.mask_prev2 && tap_x1.mask_prev2 && tap_x2.mask_prev2 &&
               tap_x0.mask_prev && mask_cur;

    right_hit = cfg.right_compare_enable && (diff_right > cfg.edge_threshold);
    down_hit  = cfg.down_compare_enable && (diff_down > cfg.edge_threshold);

    is_edge = interior && mask_all && (right_hit || down_hit);
  end

endmodule

FILE: hw/rtl/masked_neighbor_difference_edge_map_core.sv
// masked neighbor difference edge map
//
// in_item carries grey pixels with a mask bit in raster order; frame_start
// puts the pixel at column 0, row 0. out_item gives one edge mark for pixel
// (x, y) when pixel (x, y+2) is taken; rows 0 and 1 of the input give no item.
// Both channels use valid/stall: an item moves on an edge with valid high and
// stall low.
//
// one item per cycle sustained while out_stall is low. an item taken is
// registered in the input register, then processed, and its result is loaded
// into the output register. a single line store memory holds the two
// previous rows per column; it is read three columns ahead of the current
// pixel so that the right-hand taps are on hand when the pixel arrives.
//
// reset clears the position counters, the handshake state and loads the
// register defaults; the line store needs no clearing pass, as the first two
// rows of a frame fill it before any output uses it. when out_stall is high, the
// finished item holds and the input register keeps one more item before
// in_stall rises. cfg_write loads a register on any edge and is meant for idle.
module masked_neighbor_difference_edge_map_core import mnde_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_item,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  cmp_cfg_t    cmp_cfg;
  logic [8:0]  image_width, image_height;

  logic        s1_valid;
  in_item_t    s1_item;
  logic        proc;
  logic        in_take;

  pos_t        pos;
  logic [CW-1:0] wr_addr, rd_addr;

  line_entry_t tap_x0, tap_x1, tap_x2, wr_entry;
  logic        is_edge;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_cfg.edge_threshold       <= EDGE_THRESHOLD_RESET;
      cmp_cfg.right_compare_enable <= RIGHT_COMPARE_ENABLE_RESET;
      cmp_cfg.down_compare_enable  <= DOWN_COMPARE_ENABLE_RESET;
      image_width                  <= IMAGE_WIDTH_RESET;
      image_height                 <= IMAGE_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_EDGE_THRESHOLD:       cmp_cfg.edge_threshold       <= cfg_data[7:0];
        CFG_RIGHT_COMPARE_ENABLE: cmp_cfg.right_compare_enable <= cfg_data[0];
        CFG_DOWN_COMPARE_ENABLE:  cmp_cfg.down_compare_enable  <= cfg_data[0];
        CFG_IMAGE_WIDTH:          image_width                  <= cfg_data[8:0];
        CFG_IMAGE_HEIGHT:         image_height                 <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  assign proc     = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !proc;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (proc) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item <= in_item;
    end
  end

  mnde_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk          (clk),
    .rst          (rst),
    .advance      (proc),
    .frame_start  (s1_item.frame_start),
    .image_width  (image_width),
    .image_height (image_height),
    .pos          (pos),
    .wr_addr      (wr_addr),
    .rd_addr      (rd_addr)
  );

  // current row moves into prev, old prev into prev2
  assign wr_entry = '{grey_prev:  s1_item.grey_value,
                      mask_prev:  s1_item.mask_ok,
                      grey_prev2: tap_x0.grey_prev,
                      mask_prev2: tap_x0.mask_prev};

  mnde_ram #(
    .WIDTH ($bits(line_entry_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (proc),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (proc),
    .rd_addr (rd_addr),
    .rd_data (tap_x2)
  );

  // window of columns x, x+1, x+2; x+2 is the last lookahead read
  always_ff @(posedge clk) begin
    if (proc) begin
      tap_x0 <= tap_x1;
      tap_x1 <= tap_x2;
    end
  end

  mnde_edge u_edge (
    .cfg      (cmp_cfg),
    .tap_x0   (tap_x0),
    .tap_x1   (tap_x1),
    .tap_x2   (tap_x2),
    .mask_cur (s1_item.mask_ok),
    .interior (pos.interior),
    .is_edge  (is_edge)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc) begin
      out_valid <= pos.has_result;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_item.is_edge      <= is_edge;
      out_item.pixel_column <= pos.column;
      out_item.pixel_row    <= pos.row;
      out_item.frame_done   <= pos.frame_done;
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import mnde_pkg::*;

  localparam int LINE_MAX       = 256;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_AT        = 60;
  localparam int HOLD_CYCLES    = 120;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_CAP     = 50;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_item_t               in_item = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_item;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  masked_neighbor_difference_edge_map_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // register shadows
  logic [7:0] thr_reg      = EDGE_THRESHOLD_RESET;
  logic       right_en_reg = RIGHT_COMPARE_ENABLE_RESET;
  logic       down_en_reg  = DOWN_COMPARE_ENABLE_RESET;
  logic [8:0] width_reg    = IMAGE_WIDTH_RESET;
  logic [8:0] height_reg   = IMAGE_HEIGHT_RESET;

  // line stores of the predictor: row1 is the row above, row2 two rows above
  logic [7:0] grey_row1 [LINE_MAX] = '{default: '0};
  logic [7:0] grey_row2 [LINE_MAX] = '{default: '0};
  logic       mask_row1 [LINE_MAX] = '{default: '0};
  logic       mask_row2 [LINE_MAX] = '{default: '0};
  int unsigned next_col = 0;
  int unsigned next_row = 0;

  in_item_t  pixel_q[$];
  out_item_t edge_marks_q[$];

  logic pix_taken = 1'b0;
  int   pixels_in = 0;
  int   marks_seen = 0;
  int   marks_set = 0;
  int   settings_used = 0;
  int   err_count = 0;
  int   quiet_cycles = 0;

  function automatic int unsigned clamp_dim(input logic [8:0] v);
    if (v < 4) return 4;
    if (v > LINE_MAX) return LINE_MAX;
    return v;
  endfunction

  function automatic logic differs(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? a - b : b - a;
    return d > thr_reg;
  endfunction

  // mostly short gaps, a few long, and now and then a calm stretch
  function automatic int next_gap(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 100);
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= REPORT_CAP) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic predict_edge_mark(input in_item_t px);
    int unsigned w, h, x, r, y;
    logic is_mark;
    logic taps_set;
    logic [7:0] centre;
    out_item_t mark;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    if (px.frame_start) begin
      next_col = 0;
      next_row = 0;
    end
    if (next_col >= w) begin
      next_col = 0;
      next_row++;
    end
    if (next_row >= h) next_row = 0;
    x = next_col;
    r = next_row;
    if (r >= 2) begin
      y = r - 2;
      is_mark = 1'b0;
      if (x + 3 < w && y + 3 < h) begin
        taps_set = mask_row2[x] && mask_row2[x+1] && mask_row2[x+2] &&
                   mask_row1[x] && px.mask_ok;
        if (taps_set) begin
          centre = grey_row2[x];
          if (right_en_reg && differs(centre, grey_row2[x+1])) is_mark = 1'b1;
          if (down_en_reg && differs(centre, grey_row1[x])) is_mark = 1'b1;
        end
      end
      mark.is_edge      = is_mark;
      mark.pixel_column = x[7:0];
      mark.pixel_row    = y[7:0];
      mark.frame_done   = (x == w - 1) && (r == h - 1);
      edge_marks_q.push_back(mark);
    end
    grey_row2[x] = grey_row1[x];
    mask_row2[x] = mask_row1[x];
    grey_row1[x] = px.grey_value;
    mask_row1[x] = px.mask_ok;
    next_col = x + 1;
    next_row = r;
    if (next_col >= w) begin
      next_col = 0;
      next_row = r + 1;
      if (next_row >= h) next_row = 0;
    end
  endtask

  // sender: holds an item until taken, then maybe pauses
  int send_gap = 0;
  int send_calm = 0;
  always @(negedge clk) begin
    if (!rst && (!in_valid || pix_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        in_item <= pixel_q.pop_front();
        in_valid <= 1'b1;
        send_gap = next_gap(send_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off once results flow
  int recv_gap = 0;
  int recv_calm = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && marks_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      recv_gap = next_gap(recv_calm);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    pix_taken <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if ($isunknown({in_stall, out_valid})) report_mismatch("handshake output unknown");
      if (in_valid && !in_stall) begin
        predict_edge_mark(in_item);
        pixels_in++;
      end
      if (out_valid && !out_stall) begin
        marks_seen++;
        if (out_item.is_edge === 1'b1) marks_set++;
        if (edge_marks_q.size() == 0) begin
          report_mismatch($sformatf("unexpected item col %0d row %0d",
                                    out_item.pixel_column, out_item.pixel_row));
        end else begin
          want = edge_marks_q.pop_front();
          if (out_item.is_edge !== want.is_edge)
            report_mismatch($sformatf("is_edge %b, expected %b at col %0d row %0d",
                                      out_item.is_edge, want.is_edge,
                                      want.pixel_column, want.pixel_row));
          if (out_item.pixel_column !== want.pixel_column)
            report_mismatch($sformatf("pixel_column %0d, expected %0d",
                                      out_item.pixel_column, want.pixel_column));
          if (out_item.pixel_row !== want.pixel_row)
            report_mismatch($sformatf("pixel_row %0d, expected %0d",
                                      out_item.pixel_row, want.pixel_row));
          if (out_item.frame_done !== want.frame_done)
            report_mismatch($sformatf("frame_done %b, expected %b at col %0d row %0d",
                                      out_item.frame_done, want.frame_done,
                                      want.pixel_column, want.pixel_row));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // items with no result may still be in flight when the queue runs dry
  task automatic wait_drained();
    while (pixel_q.size() != 0 || in_valid || edge_marks_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [8:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_EDGE_THRESHOLD:       thr_reg = val[7:0];
      CFG_RIGHT_COMPARE_ENABLE: right_en_reg = val[0];
      CFG_DOWN_COMPARE_ENABLE:  down_en_reg = val[0];
      CFG_IMAGE_WIDTH:          width_reg = val;
      CFG_IMAGE_HEIGHT:         height_reg = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [7:0] thr, input logic ren, input logic den,
                           input logic [8:0] w, input logic [8:0] h);
    wait_drained();
    write_reg(CFG_EDGE_THRESHOLD, {1'b0, thr});
    write_reg(CFG_RIGHT_COMPARE_ENABLE, {8'd0, ren});
    write_reg(CFG_DOWN_COMPARE_ENABLE, {8'd0, den});
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    @(negedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // pixels clustered around a level so both sides of the threshold show up;
  // each batch starts a frame, so the line stores are always filled first
  task automatic queue_random_pixels(input int n_items);
    in_item_t px;
    int level;
    int g;
    int thr;
    thr = int'(thr_reg);
    level = $urandom_range(0, 255);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 19) == 0) level = $urandom_range(0, 255);
      px.frame_start = (i == 0) || ($urandom_range(0, 299) == 0);
      px.mask_ok = ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 9))
        0, 1: g = $urandom_range(0, 255);
        2: g = $urandom_range(0, 1) ? 255 : 0;
        default: g = level + int'($urandom_range(0, 2 * thr + 2)) - thr - 1;
      endcase
      if (g < 0) g = 0;
      if (g > 255) g = 255;
      px.grey_value = g[7:0];
      pixel_q.push_back(px);
    end
  endtask

  // one 5x5 frame: four inner pixels, one of them masked off on a lower tap
  logic [7:0] frame_grey [25] = '{
    8'd0,   8'd255, 8'd0,   8'd255, 8'd0,
    8'd255, 8'd0,   8'd128, 8'd0,   8'd255,
    8'd0,   8'd128, 8'd255, 8'd128, 8'd0,
    8'd255, 8'd255, 8'd0,   8'd0,   8'd255,
    8'd128, 8'd0,   8'd255, 8'd0,   8'd128};

  initial begin
    in_item_t px;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    configure(8'd100, 1'b1, 1'b1, 9'd5, 9'd5);
    for (int i = 0; i < 25; i++) begin
      px.grey_value  = frame_grey[i];
      px.mask_ok     = (i != 16);
      px.frame_start = (i == 0);
      pixel_q.push_back(px);
    end

    configure(8'd0, 1'b1, 1'b0, 9'd3, 9'd0);
    queue_random_pixels(50);
    configure(8'd255, 1'b1, 1'b1, 9'd8, 9'd6);
    queue_random_pixels(60);
    configure(8'd30, 1'b0, 1'b1, 9'd12, 9'd9);
    queue_random_pixels(70);
    configure(8'd20, 1'b0, 1'b0, 9'd7, 9'd5);
    queue_random_pixels(40);
    configure(8'($urandom_range(0, 60)), 1'b1, 1'b1, 9'd511, 9'd4);
    queue_random_pixels(530);
    configure(8'($urandom_range(0, 60)), 1'b1, 1'b0, 9'd4, 9'd300);
    queue_random_pixels(60);
    configure(8'd10, 1'b0, 1'b1, 9'd6, 9'd4);
    queue_random_pixels(40);
    configure(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 9'($urandom_range(4, 16)),
              9'($urandom_range(4, 12)));
    queue_random_pixels(40);

    wait_drained();
    if (edge_marks_q.size() != 0) report_mismatch("edge marks still outstanding");
    $display("%0d pixels in, %0d edge marks out (%0d set), %0d register settings",
             pixels_in, marks_seen, marks_set, settings_used);
    $display("long receiver hold-off %0s, %0d mismatches",
             hold_done ? "done" : "not reached", err_count);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
